@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL. They assume the module has clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/tisp_pkg.sv @@
package tisp_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_SWAP_ENABLE = 3'd0,
		REG_TYPE_INT16  = 3'd1,
		REG_TYPE_UINT16 = 3'd2,
		REG_TYPE_INT32  = 3'd3,
		REG_TYPE_UINT32 = 3'd4,
		REG_TYPE_INT64  = 3'd5,
		REG_TYPE_UINT64 = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		ROLE_CODE = 2'd0,
		ROLE_SIZE = 2'd1,
		ROLE_DATA = 2'd2
	} role_t;

	typedef struct packed {
		logic       swap_enable;
		logic [3:0] type_int16;
		logic [3:0] type_uint16;
		logic [3:0] type_int32;
		logic [3:0] type_uint32;
		logic [3:0] type_int64;
		logic [3:0] type_uint64;
	} cfg_t;

	// One front-end decision: one result, or a pair of data words for a 64-bit element.
	typedef struct packed {
		logic        pair;
		logic [31:0] word_a;
		logic [31:0] word_b;
		role_t       role;
		logic [31:0] code;
		logic [31:0] bytes;
		logic        last;
		logic        status;
	} entry_t;

	function automatic logic [31:0] rev32(input logic [31:0] w);
		rev32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [31:0] swap_low16(input logic [31:0] w);
		swap_low16 = {w[31:16], w[7:0], w[15:8]};
	endfunction

endpackage

@@ sv/tisp_regs.sv @@
module tisp_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output tisp_pkg::cfg_t     cfg
);
	import tisp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_index_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swap_enable <= 1'b0;
			cfg_q.type_int16  <= 4'd3;
			cfg_q.type_uint16 <= 4'd4;
			cfg_q.type_int32  <= 4'd5;
			cfg_q.type_uint32 <= 4'd6;
			cfg_q.type_int64  <= 4'd7;
			cfg_q.type_uint64 <= 4'd8;
		end else if (wr_en) begin
			case (idx)
				REG_SWAP_ENABLE: cfg_q.swap_enable <= pwdata[0];
				REG_TYPE_INT16:  cfg_q.type_int16  <= pwdata[3:0];
				REG_TYPE_UINT16: cfg_q.type_uint16 <= pwdata[3:0];
				REG_TYPE_INT32:  cfg_q.type_int32  <= pwdata[3:0];
				REG_TYPE_UINT32: cfg_q.type_uint32 <= pwdata[3:0];
				REG_TYPE_INT64:  cfg_q.type_int64  <= pwdata[3:0];
				REG_TYPE_UINT64: cfg_q.type_uint64 <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SWAP_ENABLE: prdata = {31'd0, cfg_q.swap_enable};
			REG_TYPE_INT16:  prdata = {28'd0, cfg_q.type_int16};
			REG_TYPE_UINT16: prdata = {28'd0, cfg_q.type_uint16};
			REG_TYPE_INT32:  prdata = {28'd0, cfg_q.type_int32};
			REG_TYPE_UINT32: prdata = {28'd0, cfg_q.type_uint32};
			REG_TYPE_INT64:  prdata = {28'd0, cfg_q.type_int64};
			REG_TYPE_UINT64: prdata = {28'd0, cfg_q.type_uint64};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/tisp_front.sv @@
module tisp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  tisp_pkg::cfg_t     cfg,
	input  logic [31:0]        body_word,
	input  logic               end_of_message,
	input  logic               body_valid,
	output logic               body_ready,
	input  logic               queue_full,
	output logic               push,
	output tisp_pkg::entry_t   push_entry
);
	import tisp_pkg::*;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_SIZE = 2'd1,
		PH_DATA = 2'd2,
		PH_HOLD = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [29:0] words_left_q, words_left_d;
	logic [31:0] code_q, code_d;
	logic [31:0] size_q, size_d;
	logic        first_q, first_d;
	logic [31:0] held_q;
	logic        accept;
	logic        emit;
	logic        done;
	logic        hold;
	logic        last;
	logic [31:0] sw_word;
	logic [31:0] size_m1;
	logic [3:0]  cur_type;
	logic        is16, is32, is64;
	entry_t      ent;

	assign body_ready = !queue_full;
	assign accept     = body_valid && body_ready;
	assign sw_word    = cfg.swap_enable ? rev32(body_word) : body_word;
	assign size_m1    = sw_word - 32'd1;
	assign cur_type   = code_q[31:28];
	assign is16       = (cur_type == cfg.type_int16) || (cur_type == cfg.type_uint16);
	assign is32       = (cur_type == cfg.type_int32) || (cur_type == cfg.type_uint32);
	assign is64       = (cur_type == cfg.type_int64) || (cur_type == cfg.type_uint64);
	assign last       = (words_left_q == 30'd0);

	always_comb begin
		phase_d      = phase_q;
		words_left_d = words_left_q;
		code_d       = code_q;
		size_d       = size_q;
		first_d      = first_q;
		emit         = 1'b1;
		done         = 1'b0;
		hold         = 1'b0;
		ent.pair     = 1'b0;
		ent.word_a   = sw_word;
		ent.word_b   = rev32(held_q);
		ent.role     = ROLE_DATA;
		ent.code     = code_q;
		ent.bytes    = size_q;
		ent.last     = 1'b0;
		ent.status   = 1'b0;
		case (phase_q)
			PH_CODE: begin
				code_d    = sw_word;
				size_d    = 32'd0;
				ent.role  = ROLE_CODE;
				ent.code  = sw_word;
				ent.bytes = 32'd0;
				phase_d   = PH_SIZE;
			end
			PH_SIZE: begin
				size_d    = sw_word;
				ent.role  = ROLE_SIZE;
				ent.bytes = sw_word;
				if (sw_word == 32'd0) begin
					ent.last = 1'b1;
					done     = 1'b1;
					phase_d  = PH_CODE;
				end else begin
					words_left_d = size_m1[31:2];
					first_d      = 1'b1;
					phase_d      = PH_DATA;
				end
			end
			PH_DATA: begin
				ent.word_a = body_word;
				if (first_q && cfg.swap_enable) begin
					if (is16) begin
						ent.word_a = swap_low16(body_word);
					end else if (is32) begin
						ent.word_a = rev32(body_word);
					end else if (is64) begin
						if (!last && !end_of_message) begin
							hold = 1'b1;
						end else begin
							ent.word_a = rev32(body_word);
						end
					end
				end
				first_d = 1'b0;
				if (hold) begin
					emit         = 1'b0;
					words_left_d = words_left_q - 30'd1;
					phase_d      = PH_HOLD;
				end else begin
					ent.last = last;
					if (last) begin
						done    = 1'b1;
						phase_d = PH_CODE;
					end else begin
						words_left_d = words_left_q - 30'd1;
					end
				end
			end
			PH_HOLD: begin
				ent.pair   = 1'b1;
				ent.word_a = rev32(body_word);
				ent.last   = last;
				if (last) begin
					done    = 1'b1;
					phase_d = PH_CODE;
				end else begin
					words_left_d = words_left_q - 30'd1;
					phase_d      = PH_DATA;
				end
			end
			default: ;
		endcase
		// A message that ends inside an item flags its results and restarts the parse.
		if (end_of_message && !done) begin
			ent.status   = 1'b1;
			phase_d      = PH_CODE;
			words_left_d = 30'd0;
			code_d       = 32'd0;
			size_d       = 32'd0;
			first_d      = 1'b0;
		end
	end

	assign push       = accept && emit;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CODE;
			words_left_q <= 30'd0;
			code_q       <= 32'd0;
			size_q       <= 32'd0;
			first_q      <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			words_left_q <= words_left_d;
			code_q       <= code_d;
			size_q       <= size_d;
			first_q      <= first_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold) begin
			held_q <= body_word;
		end
	end

endmodule

@@ sv/tisp_queue.sv @@
`include "assert_macros.svh"

module tisp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tisp_pkg::entry_t   push_entry,
	input  logic               pop,
	output tisp_pkg::entry_t   head,
	output logic               not_empty,
	output logic               full
);
	import tisp_pkg::*;

	localparam int Depth = QUEUE_DEPTH;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	entry_t            mem_q [Depth];
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW-1:0]   wr_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CntW'(Depth));
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_push_full, push && full && !do_pop, "push into a full queue")
	`ASSERT_NEVER(a_count_range, count_q > CntW'(Depth), "queue count out of range")

endmodule

@@ sv/tisp_back.sv @@
`include "assert_macros.svh"

module tisp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tisp_pkg::entry_t   head,
	input  logic               not_empty,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [31:0]        word_out,
	output logic [1:0]         word_role,
	output logic [27:0]        item_code,
	output logic [3:0]         item_type,
	output logic [31:0]        byte_count,
	output logic               item_last,
	output logic               status
);
	import tisp_pkg::*;

	logic        valid_q;
	logic        second_q;
	logic        load;
	logic        first_of_pair;
	logic [31:0] word_q;
	role_t       role_q;
	logic [31:0] code_q;
	logic [31:0] bytes_q;
	logic        last_q;
	logic        status_q;

	assign load          = not_empty && (!valid_q || result_ready);
	assign first_of_pair = head.pair && !second_q;
	assign pop           = load && !first_of_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= 1'b1;
			second_q <= first_of_pair;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q   <= second_q ? head.word_b : head.word_a;
			role_q   <= head.role;
			code_q   <= head.code;
			bytes_q  <= head.bytes;
			last_q   <= first_of_pair ? 1'b0 : head.last;
			status_q <= head.status;
		end
	end

	assign result_valid = valid_q;
	assign word_out     = word_q;
	assign word_role    = role_q;
	assign item_code    = code_q[27:0];
	assign item_type    = code_q[31:28];
	assign byte_count   = bytes_q;
	assign item_last    = last_q;
	assign status       = status_q;

	`ASSERT_IMPLY(a_pair_order, pop && head.pair, second_q, "pair popped before its second word")

endmodule

@@ sv/tlv_item_stream_parser.sv @@
// Channel   Signals                                        Direction
// body      body_valid, body_ready, body_word, end_of_message  in
// result    result_valid, result_ready, word_out .. status     out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB
//
// The front parser takes one body word per cycle while its four-entry queue has room.
// The back end delivers one result per cycle from a registered output stage unless stalled.
// A held 64-bit first word yields no result; the next word yields two, so the rate stays one.
// An accepted word passes through the queue and then the output register to its first result.
// Reset is asynchronous and active low, clears the parse state and sets register defaults.
module tlv_item_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        body_valid,
	output logic        body_ready,
	input  logic [31:0] body_word,
	input  logic        end_of_message,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] word_out,
	output logic [1:0]  word_role,
	output logic [27:0] item_code,
	output logic [3:0]  item_type,
	output logic [31:0] byte_count,
	output logic        item_last,
	output logic        status
);
	import tisp_pkg::*;

	cfg_t   cfg;
	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   not_empty;
	logic   full;

	tisp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tisp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.body_word      (body_word),
		.end_of_message (end_of_message),
		.body_valid     (body_valid),
		.body_ready     (body_ready),
		.queue_full     (full),
		.push           (push),
		.push_entry     (push_entry)
	);

	tisp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty),
		.full       (full)
	);

	tisp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.word_out     (word_out),
		.word_role    (word_role),
		.item_code    (item_code),
		.item_type    (item_type),
		.byte_count   (byte_count),
		.item_last    (item_last),
		.status       (status)
	);

endmodule
